### hw/rtl/plint_pkg.sv
// Shared constants, codes and stage payload types of the piecewise linear interpolator.
`default_nettype none
package plint_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;
  localparam int MAG_W = DATA_W + 1;
  localparam int LO_W = 16;
  localparam int HI_W = MAG_W - LO_W;
  localparam int PROD_W = 2 * MAG_W;

  typedef enum logic {OP_LOAD = 1'b0, OP_QUERY = 1'b1} op_t;
  typedef enum logic [1:0] {
    STATUS_OK = 2'd0,
    STATUS_SAT = 2'd1,
    STATUS_ZERO_WIDTH = 2'd2
  } status_t;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_EXTRAPOLATE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] xq;
    logic signed [DATA_W-1:0] xl;
    logic signed [DATA_W-1:0] xr;
    logic signed [DATA_W-1:0] yl;
    logic signed [DATA_W-1:0] yr;
  } seg_t;

  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic neg;
    logic zero_width;
    logic [DATA_W-1:0] yl;
  } job_t;
endpackage
`default_nettype wire

### hw/rtl/plint_req_if.sv
// Input word channel: load or query items.
`default_nettype none
interface plint_req_if;
  logic valid;
  logic ready;
  logic operation;
  logic [plint_pkg::SLOT_W-1:0] point_index;
  logic signed [plint_pkg::DATA_W-1:0] x_value;
  logic signed [plint_pkg::DATA_W-1:0] y_value;
  modport source (output valid, operation, point_index, x_value, y_value, input ready);
  modport sink (input valid, operation, point_index, x_value, y_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/plint_rsp_if.sv
// Result word channel.
`default_nettype none
interface plint_rsp_if;
  logic valid;
  logic ready;
  logic signed [plint_pkg::DATA_W-1:0] result_value;
  logic [1:0] status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

### hw/rtl/plint_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface plint_cfg_if;
  logic valid;
  logic ready;
  logic [plint_pkg::CFG_IDX_W-1:0] index;
  logic [plint_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolator.
// A load word writes one breakpoint at the edge it is accepted and gives no result; a query
// word gives one result after one table search stage, three product stages, 66 divider
// stages and one output stage, with one word accepted per cycle while the output
// register is free or being emptied. The divider is a 66 bit restoring divider.
// Loads take effect for every query accepted after them.
`default_nettype none
module piecewise_linear_interpolator (
  input wire logic clk,
  input wire logic rst,
  plint_req_if.sink req,
  plint_rsp_if.source rsp,
  plint_cfg_if.sink cfg
);
  import plint_pkg::*;

  logic en;
  logic acc;
  logic [COUNT_W-1:0] point_count;
  logic extrapolate;
  seg_t seg;
  logic seg_valid;
  logic [PROD_W-1:0] prod;
  job_t job_m;
  logic prod_valid;
  logic [PROD_W-1:0] quo;
  job_t job_d;
  logic div_valid;
  logic [DATA_W+2:0] sum;
  logic [DATA_W+2:0] yl_ext;
  logic [DATA_W+2:0] q_ext;
  logic q_big;
  logic signed [DATA_W-1:0] result_next;
  status_t status_next;

  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign acc = req.valid && en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= COUNT_W'(2);
      extrapolate <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POINT_COUNT: point_count <= cfg.data[COUNT_W-1:0];
        REG_EXTRAPOLATE: extrapolate <= cfg.data[0];
        default: ;
      endcase
    end
  end

  plint_table u_table (
    .clk(clk), .rst(rst), .en(en),
    .wr(acc && (req.operation == OP_LOAD)),
    .rd(acc && (req.operation == OP_QUERY)),
    .slot(req.point_index), .x(req.x_value), .y(req.y_value),
    .count(point_count), .seg(seg), .seg_valid(seg_valid)
  );

  plint_mul u_mul (
    .clk(clk), .rst(rst), .en(en), .extrapolate(extrapolate),
    .seg(seg), .seg_valid(seg_valid),
    .prod(prod), .job(job_m), .prod_valid(prod_valid)
  );

  plint_div u_div (
    .clk(clk), .rst(rst), .en(en), .prod(prod), .job_in(job_m), .in_valid(prod_valid),
    .quo(quo), .job_out(job_d), .out_valid(div_valid)
  );

  always_comb begin
    yl_ext = {{3{job_d.yl[DATA_W-1]}}, job_d.yl};
    q_ext = {2'b00, quo[DATA_W:0]};
    q_big = (quo[PROD_W-1:DATA_W+1] != '0) || (quo[DATA_W] && (quo[DATA_W-1:0] != '0));
    sum = job_d.neg ? (yl_ext - q_ext) : (yl_ext + q_ext);
    result_next = sum[DATA_W-1:0];
    status_next = STATUS_OK;
    if (job_d.zero_width) begin
      result_next = job_d.yl;
      status_next = STATUS_ZERO_WIDTH;
    end else if (q_big || (sum[DATA_W+2:DATA_W-1] != '0 && sum[DATA_W+2:DATA_W-1] != '1)) begin
      status_next = STATUS_SAT;
      if (q_big ? job_d.neg : sum[DATA_W+2]) begin
        result_next = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        result_next = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result_value <= result_next;
      rsp.status <= status_next;
    end
  end

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_SAT) |->
      (rsp.result_value == 32'sh7fffffff || rsp.result_value == 32'sh80000000))
    else $error("saturated word does not hold a range end");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (acc && req.operation == OP_LOAD) |=> !seg_valid)
    else $error("load word entered the query pipeline");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status != 2'd3))
    else $error("result word carries an undefined status");
endmodule
`default_nettype wire

### hw/rtl/plint_table.sv
// Breakpoint storage and segment search, registered segment ends out.
`default_nettype none
module plint_table (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic wr,
  input  wire logic rd,
  input  wire logic [plint_pkg::SLOT_W-1:0] slot,
  input  wire logic signed [plint_pkg::DATA_W-1:0] x,
  input  wire logic signed [plint_pkg::DATA_W-1:0] y,
  input  wire logic [plint_pkg::COUNT_W-1:0] count,
  output plint_pkg::seg_t seg,
  output logic seg_valid
);
  import plint_pkg::*;

  logic signed [DATA_W-1:0] bx [TABLE_DEPTH];
  logic signed [DATA_W-1:0] by [TABLE_DEPTH];
  logic [CNT_W-1:0] n;
  logic [IDX_W-1:0] last;
  logic [IDX_W-1:0] sel;
  logic [IDX_W-1:0] sel_r;
  logic found;

  always_ff @(posedge clk) begin
    if (wr && (int'(slot) < TABLE_DEPTH)) begin
      bx[IDX_W'(slot)] <= x;
      by[IDX_W'(slot)] <= y;
    end
  end

  always_comb begin
    if (count < COUNT_W'(2)) begin
      n = CNT_W'(2);
    end else if (int'(count) > TABLE_DEPTH) begin
      n = CNT_W'(TABLE_DEPTH);
    end else begin
      n = CNT_W'(count);
    end
    last = IDX_W'(n - CNT_W'(2));
    sel = last;
    found = 1'b0;
    if (x < bx[last]) begin
      sel = '0;
      for (int k = 0; k < TABLE_DEPTH - 2; k++) begin
        if (!found && (k + 3 <= int'(n)) && (x <= bx[k+1])) begin
          sel = IDX_W'(k);
          found = 1'b1;
        end
      end
    end
  end

  assign sel_r = sel + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (en) begin
      seg_valid <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg.xq <= x;
      seg.xl <= bx[sel];
      seg.xr <= bx[sel_r];
      seg.yl <= by[sel];
      seg.yr <= by[sel_r];
    end
  end
endmodule
`default_nettype wire

### hw/rtl/plint_mul.sv
// Clamping, differences and the split magnitude product (three stages).
`default_nettype none
module plint_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic extrapolate,
  input  wire plint_pkg::seg_t seg,
  input  wire logic seg_valid,
  output logic [plint_pkg::PROD_W-1:0] prod,
  output plint_pkg::job_t job,
  output logic prod_valid
);
  import plint_pkg::*;

  logic signed [DATA_W-1:0] yl_c;
  logic signed [DATA_W-1:0] yr_c;
  logic [MAG_W-1:0] den;
  logic [MAG_W-1:0] dy;
  logic [MAG_W-1:0] dx;
  job_t job_next;
  job_t job_a;
  job_t job_b;
  logic [MAG_W-1:0] dy_mag;
  logic [MAG_W-1:0] dx_mag;
  logic [LO_W+MAG_W-1:0] pp_lo;
  logic [HI_W+MAG_W-1:0] pp_hi;
  logic v_a;
  logic v_b;

  always_comb begin
    yl_c = seg.yl;
    yr_c = seg.yr;
    if (!extrapolate) begin
      if (seg.xq < seg.xl) begin
        yr_c = yl_c;
      end
      if (seg.xq > seg.xr) begin
        yl_c = yr_c;
      end
    end
    den = {seg.xr[DATA_W-1], seg.xr} - {seg.xl[DATA_W-1], seg.xl};
    dy = {yr_c[DATA_W-1], yr_c} - {yl_c[DATA_W-1], yl_c};
    dx = {seg.xq[DATA_W-1], seg.xq} - {seg.xl[DATA_W-1], seg.xl};
    job_next.den = den[MAG_W-1] ? (~den + MAG_W'(1)) : den;
    job_next.neg = ((dy[MAG_W-1] != dx[MAG_W-1]) != den[MAG_W-1]) && (dy != '0) && (dx != '0);
    job_next.zero_width = (den == '0);
    job_next.yl = yl_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      prod_valid <= 1'b0;
    end else if (en) begin
      v_a <= seg_valid;
      v_b <= v_a;
      prod_valid <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_a <= job_next;
      dy_mag <= dy[MAG_W-1] ? (~dy + MAG_W'(1)) : dy;
      dx_mag <= dx[MAG_W-1] ? (~dx + MAG_W'(1)) : dx;
      job_b <= job_a;
      pp_lo <= dy_mag[LO_W-1:0] * dx_mag;
      pp_hi <= dy_mag[MAG_W-1:LO_W] * dx_mag;
      job <= job_b;
      prod <= PROD_W'(pp_lo) + (PROD_W'(pp_hi) << LO_W);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/plint_div.sv
// Restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module plint_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic [plint_pkg::PROD_W-1:0] prod,
  input  wire plint_pkg::job_t job_in,
  input  wire logic in_valid,
  output logic [plint_pkg::PROD_W-1:0] quo,
  output plint_pkg::job_t job_out,
  output logic out_valid
);
  import plint_pkg::*;

  logic [MAG_W-1:0] rem [PROD_W+1];
  logic [PROD_W-1:0] num [PROD_W+1];
  job_t jobs [PROD_W+1];
  logic vld [PROD_W+1];

  assign rem[0] = '0;
  assign num[0] = prod;
  assign jobs[0] = job_in;
  assign vld[0] = in_valid;

  for (genvar s = 0; s < PROD_W; s++) begin : g_step
    logic [MAG_W:0] t;
    logic [MAG_W:0] diff;
    assign t = {rem[s], num[s][PROD_W-1]};
    assign diff = t - {1'b0, jobs[s].den};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        jobs[s+1] <= jobs[s];
        if (!diff[MAG_W]) begin
          rem[s+1] <= diff[MAG_W-1:0];
          num[s+1] <= {num[s][PROD_W-2:0], 1'b1};
        end else begin
          rem[s+1] <= t[MAG_W-1:0];
          num[s+1] <= {num[s][PROD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = num[PROD_W];
  assign job_out = jobs[PROD_W];
  assign out_valid = vld[PROD_W];
endmodule
`default_nettype wire
